[rtl/kpm_pkg.sv]
// kpm_pkg: shared types and constants for the k-mer presence marker
// used by kmer_presence_marker_unit; depends on nothing else
`default_nettype none

package kpm_pkg;

    localparam int OUT_W     = 20;   // width of the result index fields
    localparam int SYM_W     = 2;    // nucleotide code width
    localparam int CTX_W     = 4;    // context_length register width
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;

    localparam logic [CTX_W-1:0] CTX_RESET = 4'd10;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONTEXT_LENGTH = 1'b0,
        CFG_IR_ENABLE      = 1'b1
    } t_cfg_reg;

    // one entry of the result queue
    typedef struct packed {
        logic [OUT_W-1:0] fwd_index;
        logic [OUT_W-1:0] rev_index;
        logic             fwd_seen;
        logic             rev_seen;
    } t_result;

endpackage

`default_nettype wire

[rtl/kpm_ram.sv]
// kpm_ram: generic simple dual port ram, one write and one registered read per cycle
// a read of the address being written returns the old contents; no dependencies
`default_nettype none

module kpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/kmer_presence_marker_unit.sv]
// kmer_presence_marker_unit: rolling forward / reverse complement k-mer index with
// a presence bitmap held in kpm_ram rows; uses kpm_pkg
//
//  channel   direction  handshake             payload
//  ------    ---------  ---------             -------
//  symbol    in         i_valid / o_stall     i_symbol, i_restart, i_mark_enable
//  result    out        o_valid / i_stall     o_forward_index, o_reverse_index,
//                                             o_forward_seen, o_reverse_seen
//  config    in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// o_stall is held while a symbol sits in stage a: the bitmap ram has a single read port
// and each symbol needs two row reads (forward row, then reverse row); each row write
// follows in the cycle after its read. a result passes stages a, b and c into the queue.
// after reset the bitmap is swept to zero one row a cycle through all ROWS rows
// (32768 at the default), with o_stall high; config writes are taken throughout.
// a 3 entry output queue lets symbols keep flowing while a result waits on i_stall.
`default_nettype none

module kmer_presence_marker_unit #(
    parameter int MAX_WORD_LEN = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [kpm_pkg::SYM_W-1:0]      i_symbol,
    input  wire logic                           i_restart,
    input  wire logic                           i_mark_enable,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic      [kpm_pkg::OUT_W-1:0]      o_forward_index,
    output logic      [kpm_pkg::OUT_W-1:0]      o_reverse_index,
    output logic                                o_forward_seen,
    output logic                                o_reverse_seen,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [kpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [kpm_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    import kpm_pkg::*;

    localparam int IDX_W  = 2 * MAX_WORD_LEN;
    localparam int OFF_W  = (IDX_W > 5) ? 5 : IDX_W - 1;
    localparam int ROW_W  = 1 << OFF_W;
    localparam int ROW_AW = IDX_W - OFF_W;
    localparam int ROWS   = 1 << ROW_AW;
    localparam logic [CTX_W-1:0] K_MAX = CTX_W'(MAX_WORD_LEN);
    localparam int Q_DEPTH = 3;

    // configuration
    logic [CTX_W-1:0] r_ctx_len;
    logic             r_ir_en;

    // windows
    logic [IDX_W-1:0] r_fwd_win, r_rev_win;

    // bitmap clearing sweep
    logic              r_clr;
    logic [ROW_AW-1:0] r_clr_addr;

    // pipeline: a = forward row read, b = reverse row read + forward write,
    // c = reverse write + result
    logic             r_a_vld, r_b_vld, r_c_vld;
    logic [IDX_W-1:0] r_a_fwd, r_a_rev, r_b_fwd, r_b_rev, r_c_fwd, r_c_rev;
    logic             r_a_mf, r_a_mr, r_b_mf, r_b_mr, r_c_mr;
    logic             r_c_fseen;

    // write seen by the read in the previous cycle
    logic             r_hit;
    logic [ROW_W-1:0] r_hit_data;

    // output queue
    t_result r_q [Q_DEPTH];
    logic [1:0] r_rd_ptr, r_wr_ptr;
    logic [1:0] r_qcnt;   // entries in the queue
    logic [1:0] r_cnt;    // symbols transferred and not yet delivered

    logic             w_in_xfer, w_out_xfer;
    logic [CTX_W-1:0] w_k;
    logic [IDX_W-1:0] w_mask, w_fwd_base, w_rev_base, w_fwd_new, w_rev_new, w_comp;
    logic             w_we;
    logic [ROW_AW-1:0] w_waddr, w_raddr;
    logic [ROW_W-1:0] w_wdata, w_rdata, w_fwd_row, w_rev_row;
    logic [OFF_W-1:0] w_b_off, w_c_off;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_clr | r_a_vld | (r_cnt == 2'(Q_DEPTH));
    assign w_in_xfer   = i_valid & ~o_stall;
    assign o_valid     = (r_qcnt != 2'd0);
    assign w_out_xfer  = o_valid & ~i_stall;

    // effective word length and index update
    always_comb begin
        if (r_ctx_len == '0) begin
            w_k = CTX_W'(1);
        end else if (r_ctx_len > K_MAX) begin
            w_k = K_MAX;
        end else begin
            w_k = r_ctx_len;
        end
        w_mask     = {IDX_W{1'b1}} >> (IDX_W - 2 * int'(w_k));
        w_fwd_base = i_restart ? '0 : (r_fwd_win & w_mask);
        w_rev_base = i_restart ? w_mask : (r_rev_win & w_mask);
        w_comp     = IDX_W'(~i_symbol) << (2 * (int'(w_k) - 1));
        w_fwd_new  = ((w_fwd_base << 2) | IDX_W'(i_symbol)) & w_mask;
        w_rev_new  = ((w_rev_base >> 2) | w_comp) & w_mask;
    end

    // bitmap access
    assign w_b_off   = r_b_fwd[OFF_W-1:0];
    assign w_c_off   = r_c_rev[OFF_W-1:0];
    assign w_fwd_row = r_hit ? r_hit_data : w_rdata;
    assign w_rev_row = r_hit ? r_hit_data : w_rdata;
    assign w_raddr   = r_b_vld ? r_b_rev[IDX_W-1:OFF_W] : r_a_fwd[IDX_W-1:OFF_W];

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = '0;
        priority if (r_clr) begin
            w_we = 1'b1;
        end else if (r_b_vld && r_b_mf) begin
            w_we    = 1'b1;
            w_waddr = r_b_fwd[IDX_W-1:OFF_W];
            w_wdata = w_fwd_row | (ROW_W'(1) << w_b_off);
        end else if (r_c_vld && r_c_mr) begin
            w_we    = 1'b1;
            w_waddr = r_c_rev[IDX_W-1:OFF_W];
            w_wdata = w_rev_row | (ROW_W'(1) << w_c_off);
        end
    end

    kpm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx_len  <= CTX_RESET;
            r_ir_en    <= 1'b0;
            r_fwd_win  <= '0;
            r_rev_win  <= '1;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_a_vld    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_c_vld    <= 1'b0;
            r_hit      <= 1'b0;
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_qcnt     <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CONTEXT_LENGTH: r_ctx_len <= i_cfg_data[CTX_W-1:0];
                    CFG_IR_ENABLE:      r_ir_en   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + ROW_AW'(1);
                if (r_clr_addr == '1) begin
                    r_clr <= 1'b0;
                end
            end
            if (w_in_xfer) begin
                r_fwd_win <= w_fwd_new;
                r_rev_win <= w_rev_new;
            end
            r_a_vld <= w_in_xfer;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_hit   <= w_we && (w_waddr == w_raddr);
            if (r_c_vld) begin
                r_wr_ptr <= (r_wr_ptr == 2'(Q_DEPTH - 1)) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (w_out_xfer) begin
                r_rd_ptr <= (r_rd_ptr == 2'(Q_DEPTH - 1)) ? 2'd0 : r_rd_ptr + 2'd1;
            end
            r_qcnt <= r_qcnt + 2'(r_c_vld) - 2'(w_out_xfer);
            r_cnt  <= r_cnt + 2'(w_in_xfer) - 2'(w_out_xfer);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_hit_data <= w_wdata;
        if (w_in_xfer) begin
            r_a_fwd <= w_fwd_new;
            r_a_rev <= w_rev_new;
            r_a_mf  <= i_mark_enable;
            r_a_mr  <= i_mark_enable & r_ir_en;
        end
        r_b_fwd   <= r_a_fwd;
        r_b_rev   <= r_a_rev;
        r_b_mf    <= r_a_mf;
        r_b_mr    <= r_a_mr;
        r_c_fwd   <= r_b_fwd;
        r_c_rev   <= r_b_rev;
        r_c_mr    <= r_b_mr;
        r_c_fseen <= w_fwd_row[w_b_off];
        if (r_c_vld) begin
            // reverse seen uses the raw row: the same-step forward write is not in it
            r_q[r_wr_ptr] <= '{fwd_index: OUT_W'(r_c_fwd),
                               rev_index: OUT_W'(r_c_rev),
                               fwd_seen:  r_c_fseen,
                               rev_seen:  w_rdata[w_c_off]};
        end
    end

    assign o_forward_index = r_q[r_rd_ptr].fwd_index;
    assign o_reverse_index = r_q[r_rd_ptr].rev_index;
    assign o_forward_seen  = r_q[r_rd_ptr].fwd_seen;
    assign o_reverse_seen  = r_q[r_rd_ptr].rev_seen;

    // two marks of different symbols never compete for the write port
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_b_vld && r_c_vld))
        else $error("forward and reverse marks in the same cycle");

    // no symbol in flight during the clearing sweep
    a_clr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !(r_a_vld || r_b_vld || r_c_vld))
        else $error("symbol in flight while bitmap clears");

    // a result entering the queue always finds room
    a_q_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> (r_qcnt < 2'(Q_DEPTH)) && (r_cnt > r_qcnt))
        else $error("result queue overflow");

    // queue occupancy never exceeds the outstanding count
    a_cnt_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= r_cnt)
        else $error("queue holds more than outstanding");

    // transfers are never back to back
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !w_in_xfer)
        else $error("symbols transferred back to back");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// tb_top: self-checking bench for kmer_presence_marker_unit with its own model of the
// rolling k-mer windows and the presence bitmap, random stalls and config phases
// depends on kpm_pkg and kmer_presence_marker_unit
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kpm_pkg::*;

    localparam int WORD_MAX   = 10;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_GAP  = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES     = 9;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             restart;
        logic             mark;
    } t_nt_item;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    // symbol channel
    logic             sym_valid   = 1'b0;
    logic [SYM_W-1:0] sym_code    = '0;
    logic             sym_restart = 1'b0;
    logic             sym_mark    = 1'b0;
    logic             sym_took    = 1'b0;
    logic             o_stall;

    // result channel
    logic             rx_stall = 1'b1;
    logic             o_valid;
    logic [OUT_W-1:0] o_forward_index;
    logic [OUT_W-1:0] o_reverse_index;
    logic             o_forward_seen;
    logic             o_reverse_seen;

    // config channel
    logic                 cfg_valid = 1'b0;
    t_cfg_reg             cfg_index = CFG_CONTEXT_LENGTH;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 o_cfg_ready;

    // model state
    bit               seen_map [0:(1<<(2*WORD_MAX))-1];
    logic [OUT_W-1:0] fwd_word = '0;
    logic [OUT_W-1:0] rev_word = '1;
    logic [CTX_W-1:0] k_reg    = CTX_RESET;
    logic             ir_reg   = 1'b0;

    t_nt_item symbol_feed [$];
    t_result  marks_due [$];

    int err_count   = 0;
    int cycle_count = 0;
    int tx_idle_pct = 19;
    int rx_idle_pct = 19;
    int hold_req    = 0;
    int hold_ack    = 0;
    int hold_left   = 0;

    int ctx_plan [PHASES] = '{1, 0, 15, 3, 10, 6, 12, 2, 5};
    int ir_plan  [PHASES] = '{1, 0, 1, 1, 1, 0, 1, 1, 0};

    kmer_presence_marker_unit #(
        .MAX_WORD_LEN (WORD_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_valid         (sym_valid),
        .o_stall         (o_stall),
        .i_symbol        (sym_code),
        .i_restart       (sym_restart),
        .i_mark_enable   (sym_mark),
        .o_valid         (o_valid),
        .i_stall         (rx_stall),
        .o_forward_index (o_forward_index),
        .o_reverse_index (o_reverse_index),
        .o_forward_seen  (o_forward_seen),
        .o_reverse_seen  (o_reverse_seen),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shift one symbol into both windows, report the old presence bits, then mark
    function automatic t_result absorb_symbol(logic [SYM_W-1:0] sym, logic restart,
                                              logic mark);
        int               k;
        logic [21:0]      mask;
        logic [OUT_W-1:0] fwd;
        logic [OUT_W-1:0] rev;
        t_result          res;
        if (k_reg == 0)
            k = 1;
        else if (k_reg > WORD_MAX)
            k = WORD_MAX;
        else
            k = int'(k_reg);
        mask = (22'd1 << (2 * k)) - 22'd1;
        fwd  = fwd_word & mask[OUT_W-1:0];
        rev  = rev_word & mask[OUT_W-1:0];
        if (restart) begin
            fwd = '0;
            rev = mask[OUT_W-1:0];
        end
        fwd = ((fwd << 2) | OUT_W'(sym)) & mask[OUT_W-1:0];
        rev = ((rev >> 2) | (OUT_W'(2'd3 - sym) << (2 * (k - 1)))) & mask[OUT_W-1:0];
        fwd_word = fwd;
        rev_word = rev;
        res.fwd_index = fwd;
        res.rev_index = rev;
        res.fwd_seen  = seen_map[fwd];
        res.rev_seen  = seen_map[rev];
        if (mark) begin
            seen_map[fwd] = 1'b1;
            if (ir_reg)
                seen_map[rev] = 1'b1;
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
        if (want !== got) begin
            err_count++;
            $error("%s: expected 0x%05h, got 0x%05h", name, want, got);
        end
    endtask

    // symbol driver
    always @(negedge i_clk) begin
        t_nt_item nxt;
        if (!rst_n) begin
            sym_valid <= 1'b0;
        end else if (!sym_valid || sym_took) begin
            if (symbol_feed.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = symbol_feed.pop_front();
                sym_valid   <= 1'b1;
                sym_code    <= nxt.sym;
                sym_restart <= nxt.restart;
                sym_mark    <= nxt.mark;
            end else begin
                sym_valid <= 1'b0;
            end
        end
    end

    // result stall, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            rx_stall  <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            rx_stall  <= 1'b1;
            hold_left <= HOLD_LEN;
            hold_ack  <= hold_req;
        end else begin
            rx_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // monitor: predicts on each symbol transfer, checks each result transfer
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        sym_took <= rst_n && sym_valid && !o_stall;
        if (rst_n) begin
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_index)
                    CFG_CONTEXT_LENGTH: k_reg = cfg_data;
                    CFG_IR_ENABLE:      ir_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (sym_valid && !o_stall) begin
                marks_due.push_back(absorb_symbol(sym_code, sym_restart, sym_mark));
            end
            if (o_valid && !rx_stall) begin
                got.fwd_index = o_forward_index;
                got.rev_index = o_reverse_index;
                got.fwd_seen  = o_forward_seen;
                got.rev_seen  = o_reverse_seen;
                if (marks_due.size() == 0) begin
                    err_count++;
                    $error("result transfer with nothing outstanding: fwd 0x%05h rev 0x%05h",
                           got.fwd_index, got.rev_index);
                end else begin
                    want = marks_due.pop_front();
                    check_field("forward_index", want.fwd_index, got.fwd_index);
                    check_field("reverse_index", want.rev_index, got.rev_index);
                    check_field("forward_seen", OUT_W'(want.fwd_seen), OUT_W'(got.fwd_seen));
                    check_field("reverse_seen", OUT_W'(want.rev_seen), OUT_W'(got.rev_seen));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL kmer_presence_marker_unit");
            $finish;
        end
    end

    task automatic push_item(logic [SYM_W-1:0] sym, logic restart, logic mark);
        t_nt_item it;
        it.sym     = sym;
        it.restart = restart;
        it.mark    = mark;
        symbol_feed.push_back(it);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // block until every queued symbol has gone in and every result has come back
    task automatic drain();
        while (symbol_feed.size() > 0 || sym_valid || marks_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    // mostly reads that get replayed forward and as reverse complement, so words
    // recur and the seen bits get exercised; the rest is unrelated noise
    task automatic add_random_items(int count);
        logic [SYM_W-1:0] strand [$];
        int               n;
        int               len;
        int               pick;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(99);
            if (strand.size() == 0 || pick < 15) begin
                strand.delete();
                len = $urandom_range(30, 4);
                repeat (len) strand.push_back(SYM_W'($urandom_range(3)));
            end
            if (pick < 55) begin
                foreach (strand[i])
                    push_item(strand[i], (i == 0) && ($urandom_range(1) == 1),
                              $urandom_range(99) < 85);
                n += strand.size();
            end else if (pick < 80) begin
                for (int i = strand.size() - 1; i >= 0; i--)
                    push_item(2'd3 - strand[i], (i == strand.size() - 1) && ($urandom_range(1) == 1),
                              $urandom_range(99) < 85);
                n += strand.size();
            end else begin
                len = $urandom_range(8, 1);
                repeat (len)
                    push_item(SYM_W'($urandom_range(3)), $urandom_range(99) < 10,
                              $urandom_range(99) < 80);
                n += len;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // reset config: k = 10, no reverse marking; all-zero and all-three words
        push_item(2'd0, 1'b1, 1'b1);
        repeat (9) push_item(2'd0, 1'b0, 1'b1);
        repeat (10) push_item(2'd3, 1'b0, 1'b1);
        push_item(2'd1, 1'b1, 1'b0);
        push_item(2'd2, 1'b0, 1'b0);
        drain();

        // k = 2 with reverse marking: the word "03" is its own reverse complement
        write_reg(CFG_CONTEXT_LENGTH, 4'd2);
        write_reg(CFG_IR_ENABLE, 4'd1);
        repeat (2) begin
            push_item(2'd0, 1'b1, 1'b1);
            push_item(2'd3, 1'b0, 1'b1);
        end
        drain();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_CONTEXT_LENGTH, CFG_DAT_W'(ctx_plan[p]));
            write_reg(CFG_IR_ENABLE, CFG_DAT_W'(ir_plan[p]));
            tx_idle_pct = (p == 3) ? 0 : 19;
            rx_idle_pct = (p == 3) ? 0 : 19;
            if (p == 4) begin
                // sender stops mid-phase until all results are back
                add_random_items(90);
                drain();
                add_random_items(85);
            end else begin
                add_random_items(175);
            end
            if (p == 2) begin
                // results held off while symbols keep coming, so the block backs up
                repeat (50) @(posedge i_clk);
                hold_req++;
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0 && marks_due.size() == 0)
            $display("PASS kmer_presence_marker_unit");
        else
            $display("FAIL kmer_presence_marker_unit");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/kpm_pkg.sv
rtl/kpm_ram.sv
rtl/kmer_presence_marker_unit.sv
sim/tb_top.sv
